// ===== rtl/core/tbo_pkg.sv =====
package tbo_pkg;

  localparam int CoordW  = 32;
  localparam int SizeW   = 31;
  localparam int CfgIdxW = 2;
  localparam int VertW   = CoordW + 1;
  localparam int EdgeW   = VertW + 1;
  localparam int ProdW   = EdgeW + VertW;
  localparam int PrjW    = ProdW + 1;
  localparam int RadPW   = EdgeW + SizeW - 1;
  localparam int RadW    = RadPW + 1;
  localparam int CmpW    = PrjW + 1;
  localparam int NProdW  = 2 * EdgeW;
  localparam int NormW   = NProdW + 1;
  localparam int OffW    = EdgeW + 1;
  localparam int SplitW  = OffW;
  localparam int LoPW    = SplitW + 1 + OffW;
  localparam int HiPW    = NormW - SplitW + OffW;
  localparam int TermW   = NormW + OffW;
  localparam int DSumW   = TermW + 2;

  localparam logic [SizeW-1:0] SizeReset = SizeW'(65536);

  localparam logic [CfgIdxW-1:0] RegSizeX = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSizeY = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSizeZ = 2'd2;

  typedef logic        [SizeW-1:0]  size_t;
  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [VertW-1:0]  vert_t;
  typedef logic signed [EdgeW-1:0]  edge_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [PrjW-1:0]   prj_t;
  typedef logic        [RadPW-1:0]  radp_t;
  typedef logic        [RadW-1:0]   rad_t;
  typedef logic signed [CmpW-1:0]   cmp_t;
  typedef logic signed [NProdW-1:0] nprod_t;
  typedef logic signed [NormW-1:0]  norm_t;
  typedef logic signed [OffW-1:0]   off_t;
  typedef logic signed [LoPW-1:0]   lopp_t;
  typedef logic signed [HiPW-1:0]   hipp_t;
  typedef logic signed [TermW-1:0]  term_t;
  typedef logic signed [DSumW-1:0]  dsum_t;

endpackage

// ===== rtl/core/tbo_ifs.sv =====
interface tbo_tri_if;
  logic   valid;
  logic   ready;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic signed [31:0] vert_a_x;
  logic signed [31:0] vert_a_y;
  logic signed [31:0] vert_a_z;
  logic signed [31:0] vert_b_x;
  logic signed [31:0] vert_b_y;
  logic signed [31:0] vert_b_z;
  logic signed [31:0] vert_c_x;
  logic signed [31:0] vert_c_y;
  logic signed [31:0] vert_c_z;

  modport source (
    output valid, center_x, center_y, center_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, center_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    output ready
  );
endinterface

interface tbo_res_if;
  logic valid;
  logic ready;
  logic overlaps;

  modport source (output valid, overlaps, input ready);
  modport sink (input valid, overlaps, output ready);
endinterface

// ===== rtl/core/triangle_box_overlap_test.sv =====
// Each accepted item passes through the seven register stages to its result on the output register.
// Throughput: one item per cycle; the seven register stages advance together
// and hold while the output register keeps an untaken result.
// Reset (rst, synchronous): clears all stage valid bits and sets the three box
// sizes to 1.0 (Q16.16 65536).
module triangle_box_overlap_test (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tbo_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tbo_pkg::SizeW-1:0]    cfg_data,
  tbo_tri_if.sink                      tri_in,
  tbo_res_if.source                    result
);
  import tbo_pkg::*;

  localparam int Depth = 7;

  size_t        size [3];
  coord_t       center [3];
  coord_t       vert [3][3];
  vert_t        v [3][3];
  edge_t        e [3][3];
  logic         axes_ok;
  logic         plane_ok;
  logic         en;
  logic [Depth-1:0] vld;

  assign center[0]  = tri_in.center_x;
  assign center[1]  = tri_in.center_y;
  assign center[2]  = tri_in.center_z;
  assign vert[0][0] = tri_in.vert_a_x;
  assign vert[0][1] = tri_in.vert_a_y;
  assign vert[0][2] = tri_in.vert_a_z;
  assign vert[1][0] = tri_in.vert_b_x;
  assign vert[1][1] = tri_in.vert_b_y;
  assign vert[1][2] = tri_in.vert_b_z;
  assign vert[2][0] = tri_in.vert_c_x;
  assign vert[2][1] = tri_in.vert_c_y;
  assign vert[2][2] = tri_in.vert_c_z;

  assign en           = !vld[Depth-1] || result.ready;
  assign tri_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], tri_in.valid};
    end
  end

  tbo_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .size      (size)
  );

  tbo_geom u_geom (
    .clk    (clk),
    .en     (en),
    .center (center),
    .vert   (vert),
    .v      (v),
    .e      (e)
  );

  tbo_axes u_axes (
    .clk (clk),
    .en  (en),
    .v   (v),
    .e   (e),
    .s   (size),
    .ok  (axes_ok)
  );

  tbo_plane u_plane (
    .clk (clk),
    .en  (en),
    .v   (v),
    .e   (e),
    .s   (size),
    .ok  (plane_ok)
  );

  assign result.valid    = vld[Depth-1];
  assign result.overlaps = axes_ok & plane_ok;
endmodule

// ===== rtl/core/tbo_cfg.sv =====
module tbo_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tbo_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tbo_pkg::SizeW-1:0]    cfg_data,
  output tbo_pkg::size_t               size [3]
);
  import tbo_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      size[0] <= SizeReset;
      size[1] <= SizeReset;
      size[2] <= SizeReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegSizeX: size[0] <= cfg_data;
        RegSizeY: size[1] <= cfg_data;
        RegSizeZ: size[2] <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/core/tbo_geom.sv =====
module tbo_geom (
  input  logic            clk,
  input  logic            en,
  input  tbo_pkg::coord_t center [3],
  input  tbo_pkg::coord_t vert [3][3],
  output tbo_pkg::vert_t  v [3][3],
  output tbo_pkg::edge_t  e [3][3]
);
  import tbo_pkg::*;

  vert_t v1 [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          v1[i][k] <= vert_t'(vert[i][k]) - vert_t'(center[k]);
          v[i][k]  <= v1[i][k];
        end
      end
      for (int k = 0; k < 3; k++) begin
        e[0][k] <= edge_t'(v1[1][k]) - edge_t'(v1[0][k]);
        e[1][k] <= edge_t'(v1[2][k]) - edge_t'(v1[1][k]);
        e[2][k] <= edge_t'(v1[0][k]) - edge_t'(v1[2][k]);
      end
    end
  end
endmodule

// ===== rtl/core/tbo_axes.sv =====
module tbo_axes (
  input  logic           clk,
  input  logic           en,
  input  tbo_pkg::vert_t v [3][3],
  input  tbo_pkg::edge_t e [3][3],
  input  tbo_pkg::size_t s [3],
  output logic           ok
);
  import tbo_pkg::*;

  localparam int TE [9] = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
  localparam int TK [9] = '{0, 1, 2, 0, 1, 2, 0, 1, 2};
  localparam int TI [9] = '{0, 0, 1, 0, 0, 0, 0, 0, 1};
  localparam int TJ [9] = '{2, 2, 2, 2, 2, 1, 1, 1, 2};

  prod_t      m1 [9];
  prod_t      m2 [9];
  prod_t      m3 [9];
  prod_t      m4 [9];
  radp_t      r1 [9];
  radp_t      r2 [9];
  prj_t       pa [9];
  prj_t       pb [9];
  rad_t       rad [9];
  logic [8:0] edge_ok;
  logic [2:0] ext_ok_c;
  logic       ext_ok3;
  logic       ext_ok4;
  logic       ok5;
  logic       ok6;

  for (genvar t = 0; t < 9; t++) begin : g_edge
    localparam int K = TK[t];
    localparam int U = (K == 0) ? 1 : 0;
    localparam int W = (K == 2) ? 1 : 2;
    edge_t            a;
    edge_t            b;
    logic [EdgeW-1:0] abs_a;
    logic [EdgeW-1:0] abs_b;
    cmp_t             pa2;
    cmp_t             pb2;
    cmp_t             radc;
    cmp_t             nrad;

    assign a     = e[TE[t]][W];
    assign b     = e[TE[t]][U];
    assign abs_a = a[EdgeW-1] ? $unsigned(-a) : $unsigned(a);
    assign abs_b = b[EdgeW-1] ? $unsigned(-b) : $unsigned(b);

    always_ff @(posedge clk) begin
      if (en) begin
        m1[t]  <= prod_t'(a) * prod_t'(v[TI[t]][U]);
        m2[t]  <= prod_t'(b) * prod_t'(v[TI[t]][W]);
        m3[t]  <= prod_t'(a) * prod_t'(v[TJ[t]][U]);
        m4[t]  <= prod_t'(b) * prod_t'(v[TJ[t]][W]);
        r1[t]  <= radp_t'(abs_a) * radp_t'(s[U]);
        r2[t]  <= radp_t'(abs_b) * radp_t'(s[W]);
        pa[t]  <= prj_t'(m1[t]) - prj_t'(m2[t]);
        pb[t]  <= prj_t'(m3[t]) - prj_t'(m4[t]);
        rad[t] <= rad_t'(r1[t]) + rad_t'(r2[t]);
      end
    end

    assign pa2  = cmp_t'(pa[t]) <<< 1;
    assign pb2  = cmp_t'(pb[t]) <<< 1;
    assign radc = cmp_t'(rad[t]);
    assign nrad = -radc;
    assign edge_ok[t] = !((pa2 > radc && pb2 > radc) || (pa2 < nrad && pb2 < nrad));
  end

  for (genvar k = 0; k < 3; k++) begin : g_ext
    edge_t d0;
    edge_t d1;
    edge_t d2;
    edge_t sk;
    edge_t nsk;

    assign d0  = edge_t'(v[0][k]) <<< 1;
    assign d1  = edge_t'(v[1][k]) <<< 1;
    assign d2  = edge_t'(v[2][k]) <<< 1;
    assign sk  = edge_t'(s[k]);
    assign nsk = -sk;
    assign ext_ok_c[k] = !((d0 > sk && d1 > sk && d2 > sk) ||
                           (d0 < nsk && d1 < nsk && d2 < nsk));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ext_ok3 <= &ext_ok_c;
      ext_ok4 <= ext_ok3;
      ok5     <= ext_ok4 & (&edge_ok);
      ok6     <= ok5;
      ok      <= ok6;
    end
  end
endmodule

// ===== rtl/core/tbo_plane.sv =====
module tbo_plane (
  input  logic           clk,
  input  logic           en,
  input  tbo_pkg::vert_t v [3][3],
  input  tbo_pkg::edge_t e [3][3],
  input  tbo_pkg::size_t s [3],
  output logic           ok
);
  import tbo_pkg::*;

  nprod_t np [6];
  off_t   plus3 [3];
  off_t   minus3 [3];
  off_t   plus4 [3];
  off_t   minus4 [3];
  norm_t  n [3];
  lopp_t  lo_mn [3];
  lopp_t  lo_mx [3];
  hipp_t  hi_mn [3];
  hipp_t  hi_mx [3];
  term_t  t_mn [3];
  term_t  t_mx [3];
  dsum_t  dmin;
  dsum_t  dmax;

  always_ff @(posedge clk) begin
    if (en) begin
      np[0] <= nprod_t'(e[0][1]) * nprod_t'(e[1][2]);
      np[1] <= nprod_t'(e[0][2]) * nprod_t'(e[1][1]);
      np[2] <= nprod_t'(e[0][2]) * nprod_t'(e[1][0]);
      np[3] <= nprod_t'(e[0][0]) * nprod_t'(e[1][2]);
      np[4] <= nprod_t'(e[0][0]) * nprod_t'(e[1][1]);
      np[5] <= nprod_t'(e[0][1]) * nprod_t'(e[1][0]);
      for (int k = 0; k < 3; k++) begin
        plus3[k]  <= off_t'(s[k]) - (off_t'(v[0][k]) <<< 1);
        minus3[k] <= -off_t'(s[k]) - (off_t'(v[0][k]) <<< 1);
        plus4[k]  <= plus3[k];
        minus4[k] <= minus3[k];
        n[k]      <= norm_t'(np[2*k]) - norm_t'(np[2*k+1]);
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_term
    logic               pos;
    off_t               o_mn;
    off_t               o_mx;
    logic [SplitW-1:0]  n_lo;
    logic signed [NormW-SplitW-1:0] n_hi;

    assign pos  = !n[k][NormW-1] && (n[k] != '0);
    assign o_mn = pos ? minus4[k] : plus4[k];
    assign o_mx = pos ? plus4[k] : minus4[k];
    assign n_lo = n[k][SplitW-1:0];
    assign n_hi = n[k][NormW-1:SplitW];

    always_ff @(posedge clk) begin
      if (en) begin
        lo_mn[k] <= lopp_t'($signed({1'b0, n_lo})) * lopp_t'(o_mn);
        lo_mx[k] <= lopp_t'($signed({1'b0, n_lo})) * lopp_t'(o_mx);
        hi_mn[k] <= hipp_t'(n_hi) * hipp_t'(o_mn);
        hi_mx[k] <= hipp_t'(n_hi) * hipp_t'(o_mx);
        t_mn[k]  <= (term_t'(hi_mn[k]) <<< SplitW) + term_t'(lo_mn[k]);
        t_mx[k]  <= (term_t'(hi_mx[k]) <<< SplitW) + term_t'(lo_mx[k]);
      end
    end
  end

  assign dmin = dsum_t'(t_mn[0]) + dsum_t'(t_mn[1]) + dsum_t'(t_mn[2]);
  assign dmax = dsum_t'(t_mx[0]) + dsum_t'(t_mx[1]) + dsum_t'(t_mx[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      ok <= !(dmin > 0) && !dmax[DSumW-1];
    end
  end
endmodule

// ===== dv/tb.sv =====
module tb;
  import tbo_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef wide_t vec3_t [3];

  typedef struct {
    coord_t cen [3];
    coord_t vtx [3][3];
  } tri_item_t;

  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int CycleLimit = 600000;
  localparam int Settle = 12;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [SizeW-1:0] cfg_data;

  tbo_tri_if tri_in ();
  tbo_res_if result ();

  triangle_box_overlap_test u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .tri_in   (tri_in.sink),
    .result   (result.source)
  );

  size_t box_size [3];
  bit overlap_q [$];
  int errors = 0;
  int cycles = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  logic hold_start;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit span_hits(wide_t pa, wide_t pb, wide_t rad);
    wide_t lo;
    wide_t hi;
    lo = (pa < pb) ? pa : pb;
    hi = (pa < pb) ? pb : pa;
    return !(rad < 2 * lo) && !(2 * hi < -rad);
  endfunction

  function automatic bit axis_ok(vec3_t e, vec3_t vi, vec3_t vj, vec3_t s, int k);
    int u;
    int w;
    wide_t a;
    wide_t b;
    wide_t pa;
    wide_t pb;
    wide_t rad;
    u = (k == 0) ? 1 : 0;
    w = (k == 2) ? 1 : 2;
    a = e[w];
    b = e[u];
    pa = a * vi[u] - b * vi[w];
    pb = a * vj[u] - b * vj[w];
    rad = (a < 0 ? -a : a) * s[u] + (b < 0 ? -b : b) * s[w];
    return span_hits(pa, pb, rad);
  endfunction

  function automatic bit tri_box_overlap(tri_item_t t);
    vec3_t s;
    vec3_t v [3];
    vec3_t e [3];
    vec3_t n;
    wide_t lo;
    wide_t hi;
    wide_t dmin;
    wide_t dmax;
    wide_t v2;
    wide_t plus;
    wide_t minus;
    for (int k = 0; k < 3; k++) begin
      s[k] = wide_t'({1'b0, box_size[k]});
      for (int i = 0; i < 3; i++) v[i][k] = wide_t'(t.vtx[i][k]) - wide_t'(t.cen[k]);
    end
    for (int k = 0; k < 3; k++) begin
      e[0][k] = v[1][k] - v[0][k];
      e[1][k] = v[2][k] - v[1][k];
      e[2][k] = v[0][k] - v[2][k];
    end
    if (!axis_ok(e[0], v[0], v[2], s, 0)) return 1'b0;
    if (!axis_ok(e[0], v[0], v[2], s, 1)) return 1'b0;
    if (!axis_ok(e[0], v[1], v[2], s, 2)) return 1'b0;
    if (!axis_ok(e[1], v[0], v[2], s, 0)) return 1'b0;
    if (!axis_ok(e[1], v[0], v[2], s, 1)) return 1'b0;
    if (!axis_ok(e[1], v[0], v[1], s, 2)) return 1'b0;
    if (!axis_ok(e[2], v[0], v[1], s, 0)) return 1'b0;
    if (!axis_ok(e[2], v[0], v[1], s, 1)) return 1'b0;
    if (!axis_ok(e[2], v[1], v[2], s, 2)) return 1'b0;
    for (int k = 0; k < 3; k++) begin
      lo = v[0][k];
      hi = v[0][k];
      for (int i = 1; i < 3; i++) begin
        if (v[i][k] < lo) lo = v[i][k];
        if (hi < v[i][k]) hi = v[i][k];
      end
      if (s[k] < 2 * lo) return 1'b0;
      if (2 * hi < -s[k]) return 1'b0;
    end
    n[0] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
    n[1] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
    n[2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
    dmin = '0;
    dmax = '0;
    for (int k = 0; k < 3; k++) begin
      v2 = 2 * v[0][k];
      plus = s[k] - v2;
      minus = -s[k] - v2;
      dmin = dmin + n[k] * ((n[k] > 0) ? minus : plus);
      dmax = dmax + n[k] * ((n[k] > 0) ? plus : minus);
    end
    if (dmin > 0) return 1'b0;
    return dmax >= 0;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("triangle_box_overlap_test test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_start) hold_left <= 400;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    result.ready <= !rst && hold_left == 0 && !hold_start &&
                    ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      if (overlap_q.size() == 0) begin
        $error("overlaps: no item pending, actual %0b", result.overlaps);
        errors++;
      end else begin
        bit want;
        want = overlap_q.pop_front();
        if (result.overlaps !== want) begin
          $error("overlaps: expected %0b actual %0b", want, result.overlaps);
          errors++;
        end
      end
    end
  end

  task automatic send_tri(tri_item_t t);
    while ($urandom_range(99) < src_idle_pct) begin
      tri_in.valid <= 1'b0;
      @(posedge clk);
    end
    tri_in.valid <= 1'b1;
    tri_in.center_x <= t.cen[0];
    tri_in.center_y <= t.cen[1];
    tri_in.center_z <= t.cen[2];
    tri_in.vert_a_x <= t.vtx[0][0];
    tri_in.vert_a_y <= t.vtx[0][1];
    tri_in.vert_a_z <= t.vtx[0][2];
    tri_in.vert_b_x <= t.vtx[1][0];
    tri_in.vert_b_y <= t.vtx[1][1];
    tri_in.vert_b_z <= t.vtx[1][2];
    tri_in.vert_c_x <= t.vtx[2][0];
    tri_in.vert_c_y <= t.vtx[2][1];
    tri_in.vert_c_z <= t.vtx[2][2];
    do @(posedge clk); while (!tri_in.ready);
    overlap_q.push_back(tri_box_overlap(t));
  endtask

  task automatic drain();
    tri_in.valid <= 1'b0;
    while (overlap_q.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_size(logic [CfgIdxW-1:0] idx, size_t val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegSizeX) box_size[0] = val;
    else if (idx == RegSizeY) box_size[1] = val;
    else if (idx == RegSizeZ) box_size[2] = val;
    @(posedge clk);
  endtask

  task automatic set_box(size_t sx, size_t sy, size_t sz);
    write_size(RegSizeX, sx);
    write_size(RegSizeY, sy);
    write_size(RegSizeZ, sz);
  endtask

  function automatic coord_t pick_extreme();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return 32'sh0001_0000;
    endcase
  endfunction

  // mode 0: near the box, 1: full range, 2: extremes
  function automatic tri_item_t make_tri(int mode);
    tri_item_t t;
    int spread;
    spread = 1 << $urandom_range(19, 12);
    for (int k = 0; k < 3; k++) begin
      case (mode)
        0: t.cen[k] = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
        1: t.cen[k] = $urandom;
        default: t.cen[k] = pick_extreme();
      endcase
      for (int i = 0; i < 3; i++) begin
        case (mode)
          0: t.vtx[i][k] = t.cen[k] + $signed($urandom_range(0, 2 * spread)) - spread;
          1: t.vtx[i][k] = $urandom;
          default: t.vtx[i][k] = pick_extreme();
        endcase
      end
    end
    return t;
  endfunction

  function automatic tri_item_t flat_tri(coord_t x);
    tri_item_t t;
    for (int k = 0; k < 3; k++) t.cen[k] = 0;
    t.vtx[0] = '{x, 0, 0};
    t.vtx[1] = '{x, 32'sh0001_0000, 0};
    t.vtx[2] = '{x, 0, 32'sh0001_0000};
    return t;
  endfunction

  task automatic test_directed();
    tri_item_t t;
    send_tri(flat_tri(32'sh0000_8000));
    send_tri(flat_tri(32'sh0000_8001));
    send_tri(flat_tri(-32'sh0000_8000));
    send_tri(flat_tri(-32'sh0000_8001));
    t = flat_tri(0);
    t.vtx[1] = t.vtx[0];
    t.vtx[2] = t.vtx[0];
    send_tri(t);
    t.vtx[0] = '{32'sh0000_4000, 32'sh0000_4000, 0};
    t.vtx[1] = '{32'sh0002_0000, 32'sh0002_0000, 0};
    t.vtx[2] = '{32'sh0004_0000, 32'sh0004_0000, 0};
    send_tri(t);
    t.vtx[0] = '{32'sh0001_0000, 0, 0};
    t.vtx[1] = '{0, 32'sh0001_0000, 0};
    t.vtx[2] = '{0, 0, 32'sh0001_0000};
    send_tri(t);
    t.vtx[0] = '{32'sh0001_0000, 32'sh0000_8000, 32'sh0000_8000};
    t.vtx[1] = '{32'sh0000_8000, 32'sh0001_0000, 32'sh0000_8000};
    t.vtx[2] = '{32'sh0000_8000, 32'sh0000_8000, 32'sh0001_0000};
    send_tri(t);
    for (int i = 0; i < 8; i++) send_tri(make_tri(2));
    for (int k = 0; k < 3; k++) t.cen[k] = 32'sh8000_0000;
    for (int i = 0; i < 3; i++) t.vtx[i] = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
    send_tri(t);
    t.vtx[1] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000};
    send_tri(t);
    drain();
  endtask

  task automatic test_box_extremes();
    set_box(31'd1, 31'd1, 31'd1);
    send_tri(flat_tri(0));
    send_tri(flat_tri(1));
    for (int i = 0; i < 10; i++) send_tri(make_tri(i % 3));
    drain();
    set_box(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
    for (int i = 0; i < 10; i++) send_tri(make_tri(i % 3));
    drain();
    set_box(31'd1, 31'h7fff_ffff, 31'h0001_0000);
    write_size(RegUnused, 31'h0000_0005);
    for (int i = 0; i < 10; i++) send_tri(make_tri(i % 3));
    drain();
  endtask

  task automatic random_run(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(9);
      send_tri(make_tri(r < 7 ? 0 : (r < 9 ? 1 : 2)));
    end
    drain();
  endtask

  task automatic new_random_box();
    set_box(size_t'($urandom_range(1 << 18, 1)), size_t'($urandom_range(1 << 18, 1)),
            size_t'($urandom_range(1 << 18, 1)));
  endtask

  task automatic test_random();
    src_idle_pct = 33;
    snk_idle_pct = 71;
    for (int p = 0; p < 4; p++) begin
      new_random_box();
      random_run(60);
    end
    src_idle_pct = 71;
    snk_idle_pct = 33;
    for (int p = 0; p < 4; p++) begin
      new_random_box();
      random_run(60);
    end
    src_idle_pct = 0;
    snk_idle_pct = 0;
    for (int p = 0; p < 4; p++) begin
      new_random_box();
      random_run(60);
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (int i = 0; i < 40; i++) send_tri(make_tri(0));
    tri_in.valid <= 1'b0;
    while (overlap_q.size() != 0) @(posedge clk);
    @(posedge clk);
    for (int i = 0; i < 20; i++) send_tri(make_tri(0));
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = RegSizeX;
    cfg_data = '0;
    hold_start = 1'b0;
    tri_in.valid = 1'b0;
    {tri_in.center_x, tri_in.center_y, tri_in.center_z} = '0;
    {tri_in.vert_a_x, tri_in.vert_a_y, tri_in.vert_a_z} = '0;
    {tri_in.vert_b_x, tri_in.vert_b_y, tri_in.vert_b_z} = '0;
    {tri_in.vert_c_x, tri_in.vert_c_y, tri_in.vert_c_z} = '0;
    result.ready = 1'b0;
    for (int k = 0; k < 3; k++) box_size[k] = SizeReset;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_box_extremes();
    set_box(SizeReset, SizeReset, SizeReset);
    test_backpressure();
    test_random();
    if (errors == 0) begin
      $display("triangle_box_overlap_test test passed");
    end else begin
      $display("triangle_box_overlap_test test failed");
    end
    $finish;
  end

endmodule
